/* rtl/centered_moving_average_macros.svh */
// assertion macros for the moving average block
`ifndef CENTERED_MOVING_AVERAGE_MACROS_SVH
`define CENTERED_MOVING_AVERAGE_MACROS_SVH

// property that must hold at each edge outside reset
`define CMA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define CMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/cma_pkg.sv */
package cma_pkg;
  localparam int unsigned Channels = 9;
  localparam int unsigned MaxHalf = 15;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned HistRows = 2 * MaxHalf + 1;
  localparam int unsigned HistBits = $clog2(HistRows);
  localparam int unsigned ChBits = $clog2(Channels);
  localparam int unsigned SeenBits = $clog2(HistRows + 1);
  localparam int unsigned SumBits = SampleBits + $clog2(HistRows);
  localparam int unsigned MemDepth = HistRows * Channels;
  localparam int unsigned MemBits = $clog2(MemDepth);
  localparam int unsigned DivBits = 6;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [SumBits-1:0] sum_t;
endpackage

/* rtl/centered_moving_average.sv */
// sequence: accept, write the row into history channel by channel, decide, then per
//   channel either a smoothed row (2h+1 read and add pairs, a 21-step shared
//   restoring divide, store) or a raw row (read, store), then emit and finish
// a final row adds up to h raw rows after it; not ready meanwhile
// one item at a time; emit waits while the output register is still held
// reset (rst_ni low, async) clears the sequencer, row count and half width
`include "centered_moving_average_macros.svh"
module centered_moving_average import cma_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [3:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SampleBits-1:0] sample_ch0_i,
  input  logic signed [SampleBits-1:0] sample_ch1_i,
  input  logic signed [SampleBits-1:0] sample_ch2_i,
  input  logic signed [SampleBits-1:0] sample_ch3_i,
  input  logic signed [SampleBits-1:0] sample_ch4_i,
  input  logic signed [SampleBits-1:0] sample_ch5_i,
  input  logic signed [SampleBits-1:0] sample_ch6_i,
  input  logic signed [SampleBits-1:0] sample_ch7_i,
  input  logic signed [SampleBits-1:0] sample_ch8_i,
  input  logic                         final_row_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SampleBits-1:0] smoothed_ch0_o,
  output logic signed [SampleBits-1:0] smoothed_ch1_o,
  output logic signed [SampleBits-1:0] smoothed_ch2_o,
  output logic signed [SampleBits-1:0] smoothed_ch3_o,
  output logic signed [SampleBits-1:0] smoothed_ch4_o,
  output logic signed [SampleBits-1:0] smoothed_ch5_o,
  output logic signed [SampleBits-1:0] smoothed_ch6_o,
  output logic signed [SampleBits-1:0] smoothed_ch7_o,
  output logic signed [SampleBits-1:0] smoothed_ch8_o,
  output logic                         last_out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_DECIDE, S_RD, S_SUM, S_DIV, S_STORE, S_EMIT, S_FLUSH
  } state_e;

  state_e state_q;
  logic [3:0] half_q;
  logic [SeenBits-1:0] seen_q, cnt_q;
  logic [HistBits-1:0] head_q, k_q, row_q;
  logic [ChBits-1:0] ch_q;
  logic [HistBits:0] cyc_q;
  logic [DivBits-1:0] dstep_q;
  logic fin_q, avg_q, last_q;
  sample_t in_q [Channels];
  sample_t res_q [Channels];
  sum_t acc_q;
  logic [SumBits-1:0] quo_q, rem_q;
  logic neg_q;
  logic out_valid_q;
  sample_t mem_q [MemDepth];
  sample_t rd_q;
  logic [MemBits-1:0] wa, ra;
  logic we;

  // window geometry from the current half width
  logic [HistBits:0] win;
  logic [SumBits-1:0] divisor;
  assign win = {1'b0, half_q, 1'b1};
  assign divisor = SumBits'(win);

  // row k back from newest lives at (head - k) mod HistRows
  function automatic logic [HistBits-1:0] slot(input logic [HistBits-1:0] hd,
                                               input logic [HistBits-1:0] k);
    logic [HistBits:0] t;
    t = {1'b0, hd} + HistBits'(HistRows) - {1'b0, k};
    if (t >= (HistBits+1)'(HistRows)) t = t - (HistBits+1)'(HistRows);
    return t[HistBits-1:0];
  endfunction

  assign wa = MemBits'(head_q) * MemBits'(Channels) + MemBits'(ch_q);
  assign ra = MemBits'(slot(head_q, row_q)) * MemBits'(Channels) + MemBits'(ch_q);
  assign we = (state_q == S_WRITE);

  // history memory, one sample per address
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= in_q[ch_q];
    rd_q <= mem_q[ra];
  end

  // restoring divide step on magnitude
  logic [SumBits:0] trial;
  assign trial = {rem_q, quo_q[SumBits-1]} - {1'b0, divisor};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      half_q <= '0;
      seen_q <= '0;
      head_q <= '0;
      out_valid_q <= 1'b0;
      fin_q <= 1'b0;
      cnt_q <= '0;
      ch_q <= '0;
      k_q <= '0;
      row_q <= '0;
      cyc_q <= '0;
      dstep_q <= '0;
      avg_q <= 1'b0;
      last_q <= 1'b0;
      acc_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      neg_q <= 1'b0;
      for (int i = 0; i < Channels; i++) begin
        in_q[i] <= '0;
        res_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) half_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i && state_q != S_EMIT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q[0] <= sample_ch0_i; in_q[1] <= sample_ch1_i;
            in_q[2] <= sample_ch2_i; in_q[3] <= sample_ch3_i;
            in_q[4] <= sample_ch4_i; in_q[5] <= sample_ch5_i;
            in_q[6] <= sample_ch6_i; in_q[7] <= sample_ch7_i;
            in_q[8] <= sample_ch8_i;
            fin_q <= final_row_i;
            head_q <= (head_q == HistBits'(HistRows - 1)) ? '0 : head_q + 1'b1;
            cnt_q <= (seen_q == SeenBits'(HistRows)) ? seen_q : seen_q + 1'b1;
            ch_q <= '0;
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (ch_q == ChBits'(Channels - 1)) begin
            ch_q <= '0;
            state_q <= S_DECIDE;
          end else ch_q <= ch_q + 1'b1;
        end
        S_DECIDE: begin
          // emit row h back when it exists, average when the window is full
          if (cnt_q > SeenBits'(half_q)) begin
            avg_q <= ({1'b0, cnt_q} >= (SeenBits+1)'(win));
            last_q <= fin_q && (half_q == '0);
            row_q <= (cnt_q >= SeenBits'(win)) ? '0 : HistBits'(half_q);
            acc_q <= '0;
            cyc_q <= '0;
            ch_q <= '0;
            state_q <= S_RD;
          end else begin
            k_q <= (cnt_q < SeenBits'(half_q)) ? HistBits'(cnt_q) : HistBits'(half_q);
            state_q <= S_FLUSH;
          end
        end
        S_RD: state_q <= S_SUM;  // read latency
        S_SUM: begin
          if (!avg_q) begin
            res_q[ch_q] <= rd_q;
            state_q <= S_STORE;
          end else begin
            acc_q <= acc_q + SumBits'(rd_q);
            if (HistBits'(cyc_q) == HistBits'(win - 1)) begin
              state_q <= S_DIV;
              dstep_q <= '0;
              row_q <= '0;
            end else begin
              cyc_q <= cyc_q + 1'b1;
              row_q <= row_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        S_DIV: begin
          if (dstep_q == '0) begin
            neg_q <= acc_q[SumBits-1];
            quo_q <= acc_q[SumBits-1] ? SumBits'(-acc_q) : acc_q;
            rem_q <= '0;
            dstep_q <= DivBits'(1);
          end else if (dstep_q <= DivBits'(SumBits)) begin
            if (!trial[SumBits]) begin
              rem_q <= trial[SumBits-1:0];
              quo_q <= {quo_q[SumBits-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[SumBits-2:0], quo_q[SumBits-1]};
              quo_q <= {quo_q[SumBits-2:0], 1'b0};
            end
            dstep_q <= dstep_q + 1'b1;
          end else begin
            res_q[ch_q] <= neg_q ? SampleBits'(-quo_q) : SampleBits'(quo_q);
            state_q <= S_STORE;
          end
        end
        S_STORE: begin
          cyc_q <= '0;
          acc_q <= '0;
          if (ch_q == ChBits'(Channels - 1)) state_q <= S_EMIT;
          else begin
            ch_q <= ch_q + 1'b1;
            state_q <= S_RD;
            if (!avg_q) row_q <= row_q;
            else row_q <= '0;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          // raw rows k-1 .. 0 after the final row
          if (!fin_q) begin
            seen_q <= cnt_q;
            state_q <= S_IDLE;
          end else if (k_q == '0) begin
            seen_q <= '0;
            state_q <= S_IDLE;
          end else begin
            avg_q <= 1'b0;
            row_q <= k_q - 1'b1;
            last_q <= (k_q == 1);
            k_q <= k_q - 1'b1;
            ch_q <= '0;
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_DECIDE && cnt_q > SeenBits'(half_q))
        k_q <= (cnt_q < SeenBits'(half_q)) ? HistBits'(cnt_q) : HistBits'(half_q);
    end
  end

  logic out_busy;
  assign out_busy = out_valid_q && !out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // result register holds until taken
  sample_t oq [Channels];
  logic olast_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && !out_busy) begin
      for (int i = 0; i < Channels; i++) oq[i] <= res_q[i];
      olast_q <= last_q;
    end
  end
  assign smoothed_ch0_o = oq[0];
  assign smoothed_ch1_o = oq[1];
  assign smoothed_ch2_o = oq[2];
  assign smoothed_ch3_o = oq[3];
  assign smoothed_ch4_o = oq[4];
  assign smoothed_ch5_o = oq[5];
  assign smoothed_ch6_o = oq[6];
  assign smoothed_ch7_o = oq[7];
  assign smoothed_ch8_o = oq[8];
  assign last_out_o = olast_q;

  `CMA_ASSERT(a_ready_idle, in_ready_o == (state_q == S_IDLE))
  `CMA_ASSERT(a_seen_range, seen_q <= SeenBits'(HistRows))
  `CMA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(last_out_o))
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
module testbench;
  import cma_pkg::*;

  localparam int unsigned WatchdogLimit = 200000;
  localparam int unsigned DrainCycles = 2000;

  typedef struct packed {
    sample_t [Channels-1:0] ch;
    logic                   last;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  sample_t smp [Channels];
  logic final_row_i;
  logic out_valid_o;
  logic out_ready_i;
  sample_t sm [Channels];
  logic last_out_o;

  // model state
  sample_t history_q [HistRows][Channels];
  int unsigned seen_rows;
  int unsigned half_width;
  row_t pending_rows [$];

  int unsigned mismatches;
  int unsigned idle_cycles;
  bit timed_out;

  centered_moving_average i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .sample_ch0_i(smp[0]), .sample_ch1_i(smp[1]), .sample_ch2_i(smp[2]),
    .sample_ch3_i(smp[3]), .sample_ch4_i(smp[4]), .sample_ch5_i(smp[5]),
    .sample_ch6_i(smp[6]), .sample_ch7_i(smp[7]), .sample_ch8_i(smp[8]),
    .final_row_i,
    .out_valid_o, .out_ready_i,
    .smoothed_ch0_o(sm[0]), .smoothed_ch1_o(sm[1]), .smoothed_ch2_o(sm[2]),
    .smoothed_ch3_o(sm[3]), .smoothed_ch4_o(sm[4]), .smoothed_ch5_o(sm[5]),
    .smoothed_ch6_o(sm[6]), .smoothed_ch7_o(sm[7]), .smoothed_ch8_o(sm[8]),
    .last_out_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // build a result row from one history entry
  function automatic row_t held_row(int unsigned idx, logic last);
    row_t r;
    for (int j = 0; j < Channels; j++) r.ch[j] = history_q[idx][j];
    r.last = last;
    return r;
  endfunction

  // predict the rows emitted for one accepted item
  task automatic predict_rows(sample_t vals [Channels], logic fin);
    int unsigned h;
    int unsigned cnt;
    int unsigned top;
    longint sum;
    row_t r;
    h = half_width;
    for (int k = HistRows - 1; k > 0; k--) history_q[k] = history_q[k-1];
    for (int j = 0; j < Channels; j++) history_q[0][j] = vals[j];
    cnt = (seen_rows + 1 > HistRows) ? HistRows : seen_rows + 1;
    if (cnt > h) begin
      if (cnt >= 2 * h + 1) begin
        for (int j = 0; j < Channels; j++) begin
          sum = 0;
          for (int k = 0; k <= 2 * h; k++) sum += longint'(history_q[k][j]);
          r.ch[j] = sample_t'(sum / longint'(2 * h + 1));
        end
      end else begin
        r = held_row(h, 1'b0);
      end
      r.last = fin && (h == 0);
      pending_rows.push_back(r);
    end
    if (fin) begin
      top = (cnt < h) ? cnt : h;
      for (int k = top; k > 0; k--) pending_rows.push_back(held_row(k - 1, k == 1));
      seen_rows = 0;
    end else begin
      seen_rows = cnt;
    end
  endtask

  // send one item, predicting at acceptance
  task automatic send_row(sample_t vals [Channels], logic fin);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int j = 0; j < Channels; j++) smp[j] <= vals[j];
    final_row_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    predict_rows(vals, fin);
  endtask

  task automatic send_random(logic fin, int unsigned mode);
    sample_t v [Channels];
    for (int j = 0; j < Channels; j++) begin
      case (mode)
        0: v[j] = sample_t'(16'h7fff);
        1: v[j] = sample_t'(16'h8000);
        default: v[j] = sample_t'($urandom());
      endcase
    end
    send_row(v, fin);
  endtask

  // wait for all results, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_half(int unsigned h);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= h[3:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    half_width = h;
  endtask

  task automatic send_sequence(int unsigned len, int unsigned mode);
    for (int unsigned i = 0; i < len; i++) send_random(i == len - 1, mode);
  endtask

  // directed extremes: full scale, short and single-row sequences
  task automatic test_directed();
    set_half(0);
    send_sequence(2, 0);
    send_sequence(1, 1);
    set_half(1);
    send_sequence(4, 1);
    send_sequence(1, 0);
    set_half(15);
    send_sequence(5, 0);
    send_sequence(10, 1);
  endtask

  // random sequences under several window settings
  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned h;
    int unsigned len;
    sent = 0;
    while (sent < 430) begin
      h = $urandom_range(0, 3) == 0 ? 15 : $urandom_range(0, 4);
      set_half(h);
      repeat ($urandom_range(1, 4)) begin
        len = $urandom_range(0, 4) == 0 ? $urandom_range(30, 45) : $urandom_range(1, 12);
        send_sequence(len, 2 + $urandom_range(0, 1) * ($urandom_range(0, 9) == 0 ? 0 : 1));
        sent += len;
      end
    end
  endtask

  // result checking
  always @(posedge clk_i) begin
    row_t exp_row;
    bit bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result row");
      end else begin
        exp_row = pending_rows.pop_front();
        bad = (exp_row.last !== last_out_o);
        for (int j = 0; j < Channels; j++) if (exp_row.ch[j] !== sm[j]) bad = 1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("row mismatch: expected last=%0b", exp_row.last);
            for (int j = 0; j < Channels; j++)
              $display("  ch%0d expected %0d actual %0d", j, exp_row.ch[j], sm[j]);
            $display("  last actual %0b", last_out_o);
          end
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int unsigned wait_n;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
        if (wait_n != 0) begin
          out_ready_i <= 1'b0;
          repeat (wait_n) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
    end
  end

  // watchdog on cycles with no transfer
  initial begin
    idle_cycles = 0;
    timed_out = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        timed_out = 1;
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    final_row_i = 1'b0;
    for (int j = 0; j < Channels; j++) smp[j] = '0;
    seen_rows = 0;
    half_width = 0;
    mismatches = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sequences();
    wait_idle();
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* centered_moving_average.f */
+incdir+rtl
rtl/cma_pkg.sv
rtl/centered_moving_average.sv
tb/sv/testbench.sv
